// ===== src/bitmap_page_allocator_defines.svh =====
// Assertion macros shared by the page allocator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/bpa_pkg.sv =====
// Shared types and constants of the bitmap page allocator.
// No dependencies; used by the allocator top level.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

   localparam int POOL_PAGES = 4096;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int BIT_SEL_W  = $clog2(WORD_BITS);
   localparam int WORD_AW    = $clog2(MAP_WORDS);
   localparam int PAGE_IDX_W = WORD_AW + BIT_SEL_W;
   localparam int POS_W      = PAGE_IDX_W + 1;

   localparam int PAGE_W   = 20;
   localparam int COUNT_W  = 13;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_RUN = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_USED   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FREE   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_OUT    = 3'd4;

   localparam logic REG_POOL_BASE  = 1'b0;
   localparam logic REG_POOL_PAGES = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [PAGE_W-1:0]  first_page;
      logic [COUNT_W-1:0] page_count;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   result_page;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the page bitmap of the allocator.
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/bitmap_page_allocator.sv =====
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  bpa_pkg::req_type (operation, start, count)
// rsp      out        rsp_valid/rsp_stall  bpa_pkg::rsp_type (status, result page)
// csr      in/out     APB-style, pready=1  pool_base @0x0, pool_pages @0x4
//
// One request at a time: a check state (plus a range state for free and reserve), then
// the bit-serial scan or mark of each page visited, with a load and a load-wait state per
// bitmap word read and a flush state per word written back.
// The word-at-a-time bitmap RAM and the one-bit-per-cycle sequencer set the rate.
// Reset is synchronous; row valid bits make the map read as all free at once.
// A waiting result does not block the next request; a stalled result does
// hold the finishing request until it moves.
// Depends on bpa_pkg, bpa_ram and bitmap_page_allocator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_page_allocator_defines.svh"

module bitmap_page_allocator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire bpa_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output bpa_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [bpa_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [bpa_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [bpa_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_RANGE,
      S_LOAD,
      S_LOADW,
      S_SCAN,
      S_SETUP,
      S_MARK,
      S_FLUSH,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   bpa_pkg::rsp_type                    rsp_ff, rsp_in;
   logic [bpa_pkg::MAP_WORDS-1:0]       row_valid_ff, row_valid_in;
   logic [bpa_pkg::PAGE_W-1:0]          pool_base_ff, pool_base_in;
   logic [bpa_pkg::COUNT_W-1:0]         pool_pages_ff, pool_pages_in;

   logic [bpa_pkg::OP_W-1:0]            op_ff, op_in;
   logic [bpa_pkg::PAGE_W-1:0]          start_ff, start_in;
   logic [bpa_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [bpa_pkg::PAGE_W-1:0]          diff_ff, diff_in;
   logic                                borrow_ff, borrow_in;
   logic [bpa_pkg::POS_W-1:0]           pos_ff, pos_in;
   logic [bpa_pkg::COUNT_W-1:0]         run_ff, run_in;
   logic [bpa_pkg::COUNT_W-1:0]         left_ff, left_in;
   logic [bpa_pkg::PAGE_IDX_W-1:0]      alloc_idx_ff, alloc_idx_in;
   logic                                set_val_ff, set_val_in;
   logic                                searching_ff, searching_in;
   logic                                more_ff, more_in;
   logic                                dirty_ff, dirty_in;
   logic [bpa_pkg::WORD_AW-1:0]         word_addr_ff, word_addr_in;
   logic [bpa_pkg::WORD_BITS-1:0]       word_ff, word_in;
   logic [bpa_pkg::STATUS_W-1:0]        status_ff, status_in;

   logic                                req_xfer;
   logic                                csr_write;
   logic [bpa_pkg::COUNT_W-1:0]         pool_size;
   logic                                cur_bit;
   logic [bpa_pkg::COUNT_W-1:0]         run_next;
   logic [bpa_pkg::PAGE_W:0]            diff_wide;
   logic [bpa_pkg::PAGE_W:0]            run_end;

   logic                                ram_wr_en;
   logic                                ram_rd_en;
   logic [bpa_pkg::WORD_AW-1:0]         ram_rd_addr;
   logic [bpa_pkg::WORD_BITS-1:0]       ram_rd_data;

   bpa_ram #(
      .WIDTH (bpa_pkg::WORD_BITS),
      .DEPTH (bpa_pkg::MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (word_addr_ff),
      .wr_data (word_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         bpa_pkg::REG_POOL_BASE:  csr_prdata = {12'd0, pool_base_ff};
         bpa_pkg::REG_POOL_PAGES: csr_prdata = {19'd0, pool_pages_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // Clamp an oversized pool register to the map size.
   assign pool_size = (pool_pages_ff > bpa_pkg::COUNT_W'(bpa_pkg::POOL_PAGES))
                    ? bpa_pkg::COUNT_W'(bpa_pkg::POOL_PAGES) : pool_pages_ff;

   assign cur_bit   = word_ff[pos_ff[bpa_pkg::BIT_SEL_W-1:0]];
   assign run_next  = run_ff + bpa_pkg::COUNT_W'(1);
   assign diff_wide = {1'b0, start_ff} - {1'b0, pool_base_ff};
   assign run_end   = {1'b0, diff_ff} + (bpa_pkg::PAGE_W + 1)'(count_ff);

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      row_valid_in  = row_valid_ff;
      pool_base_in  = pool_base_ff;
      pool_pages_in = pool_pages_ff;
      op_in         = op_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      diff_in       = diff_ff;
      borrow_in     = borrow_ff;
      pos_in        = pos_ff;
      run_in        = run_ff;
      left_in       = left_ff;
      alloc_idx_in  = alloc_idx_ff;
      set_val_in    = set_val_ff;
      searching_in  = searching_ff;
      more_in       = more_ff;
      dirty_in      = dirty_ff;
      word_addr_in  = word_addr_ff;
      word_in       = word_ff;
      status_in     = status_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = pos_ff[bpa_pkg::PAGE_IDX_W-1:bpa_pkg::BIT_SEL_W];

      if (csr_write) begin
         unique case (csr_paddr[2])
            bpa_pkg::REG_POOL_BASE:  pool_base_in  = csr_pwdata[bpa_pkg::PAGE_W-1:0];
            bpa_pkg::REG_POOL_PAGES: pool_pages_in = csr_pwdata[bpa_pkg::COUNT_W-1:0];
            default:                 pool_base_in  = pool_base_ff;
         endcase
      end

      // Drop the result once it transfers; a new one may load below.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in    = req_data.operation;
               start_in = req_data.first_page;
               count_in = req_data.page_count;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in    = bpa_pkg::STATUS_OUT;
            pos_in       = '0;
            run_in       = '0;
            searching_in = 1'b1;
            diff_in      = diff_wide[bpa_pkg::PAGE_W-1:0];
            borrow_in    = diff_wide[bpa_pkg::PAGE_W];
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else if (op_ff == bpa_pkg::OP_ALLOC) begin
               state_in = S_LOAD;
            end else if (op_ff == bpa_pkg::OP_FREE || op_ff == bpa_pkg::OP_RESERVE) begin
               state_in = S_RANGE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RANGE: begin
            if (borrow_ff || run_end > (bpa_pkg::PAGE_W + 1)'(pool_size)) begin
               state_in = S_DONE;
            end else begin
               pos_in       = bpa_pkg::POS_W'(diff_ff);
               left_in      = count_ff;
               set_val_in   = (op_ff == bpa_pkg::OP_RESERVE);
               searching_in = 1'b0;
               state_in     = S_LOAD;
            end
         end
         S_LOAD: begin
            ram_rd_en    = 1'b1;
            word_addr_in = pos_ff[bpa_pkg::PAGE_IDX_W-1:bpa_pkg::BIT_SEL_W];
            state_in     = S_LOADW;
         end
         S_LOADW: begin
            // Rows never written read as all free.
            word_in  = row_valid_ff[word_addr_ff] ? ram_rd_data : '0;
            dirty_in = 1'b0;
            state_in = searching_ff ? S_SCAN : S_MARK;
         end
         S_SCAN: begin
            if (pos_ff == bpa_pkg::POS_W'(pool_size)) begin
               status_in = bpa_pkg::STATUS_NO_RUN;
               state_in  = S_DONE;
            end else if (!cur_bit && run_next == count_ff) begin
               state_in = S_SETUP;
            end else begin
               run_in = cur_bit ? '0 : run_next;
               pos_in = pos_ff + bpa_pkg::POS_W'(1);
               if (&pos_ff[bpa_pkg::BIT_SEL_W-1:0]) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_SETUP: begin
            // Rewind from the run's last page to its first.
            alloc_idx_in = pos_ff[bpa_pkg::PAGE_IDX_W-1:0]
                         - count_ff[bpa_pkg::PAGE_IDX_W-1:0]
                         + bpa_pkg::PAGE_IDX_W'(1);
            pos_in       = {1'b0, alloc_idx_in};
            left_in      = count_ff;
            set_val_in   = 1'b1;
            searching_in = 1'b0;
            state_in     = S_LOAD;
         end
         S_MARK: begin
            if (cur_bit == set_val_ff) begin
               status_in = set_val_ff ? bpa_pkg::STATUS_USED : bpa_pkg::STATUS_FREE;
               more_in   = 1'b0;
               state_in  = dirty_ff ? S_FLUSH : S_DONE;
            end else begin
               word_in[pos_ff[bpa_pkg::BIT_SEL_W-1:0]] = set_val_ff;
               dirty_in = 1'b1;
               left_in  = left_ff - bpa_pkg::COUNT_W'(1);
               pos_in   = pos_ff + bpa_pkg::POS_W'(1);
               if (left_ff == bpa_pkg::COUNT_W'(1)) begin
                  status_in = bpa_pkg::STATUS_OK;
                  more_in   = 1'b0;
                  state_in  = S_FLUSH;
               end else if (&pos_ff[bpa_pkg::BIT_SEL_W-1:0]) begin
                  more_in  = 1'b1;
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            ram_wr_en                  = 1'b1;
            row_valid_in[word_addr_ff] = 1'b1;
            dirty_in                   = 1'b0;
            state_in                   = more_ff ? S_LOAD : S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.result_page =
                  (op_ff == bpa_pkg::OP_ALLOC && status_ff == bpa_pkg::STATUS_OK)
                  ? pool_base_ff + bpa_pkg::PAGE_W'(alloc_idx_ff) : '0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         row_valid_ff  <= '0;
         pool_base_ff  <= '0;
         pool_pages_ff <= bpa_pkg::COUNT_W'(bpa_pkg::POOL_PAGES);
         dirty_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         row_valid_ff  <= row_valid_in;
         pool_base_ff  <= pool_base_in;
         pool_pages_ff <= pool_pages_in;
         dirty_ff      <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      op_ff        <= op_in;
      start_ff     <= start_in;
      count_ff     <= count_in;
      diff_ff      <= diff_in;
      borrow_ff    <= borrow_in;
      pos_ff       <= pos_in;
      run_ff       <= run_in;
      left_ff      <= left_in;
      alloc_idx_ff <= alloc_idx_in;
      set_val_ff   <= set_val_in;
      searching_ff <= searching_in;
      more_ff      <= more_in;
      word_addr_ff <= word_addr_in;
      word_ff      <= word_in;
      status_ff    <= status_in;
   end

   `BPA_ASSERT_IMPL(a_write_only_dirty, clock, reset, ram_wr_en, dirty_ff,
      "bitmap write-back without a modified word")
   `BPA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_xfer, req_stall,
      "request channel not stalled after a transfer")
   `BPA_ASSERT_IMPL(a_page_zero_on_error, clock, reset,
      rsp_valid_ff && rsp_ff.status != bpa_pkg::STATUS_OK,
      rsp_ff.result_page == '0, "nonzero result page on a failed request")
   `BPA_ASSERT_IMPL(a_mark_count_live, clock, reset, state_ff == S_MARK,
      left_ff != '0, "marking with no pages left")

endmodule

`default_nettype wire

// ===== bench/tb_bitmap_page_allocator.sv =====
// Self-checking bench for bitmap_page_allocator: directed and random requests
// checked against a behavioral page map, across several pool settings.
// Depends on bpa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_bitmap_page_allocator;

   localparam logic [bpa_pkg::OP_W-1:0]   OP_UNUSED       = 2'd3;
   localparam logic [bpa_pkg::CSR_AW-1:0] ADDR_POOL_BASE  = {bpa_pkg::REG_POOL_BASE, 2'b00};
   localparam logic [bpa_pkg::CSR_AW-1:0] ADDR_POOL_PAGES = {bpa_pkg::REG_POOL_PAGES, 2'b00};
   localparam int                         CYCLE_LIMIT     = 10_000_000;

   typedef struct {
      int first;
      int count;
   } page_run_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   bpa_pkg::req_type                req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   bpa_pkg::rsp_type                rsp_data;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [bpa_pkg::CSR_AW-1:0]      csr_paddr;
   logic [bpa_pkg::CSR_DW-1:0]      csr_pwdata;
   logic [bpa_pkg::CSR_DW-1:0]      csr_prdata;
   logic                            csr_pready;

   // behavioral copy of the pool
   bit                              used_map [bpa_pkg::POOL_PAGES];
   logic [bpa_pkg::PAGE_W-1:0]      model_base;
   logic [bpa_pkg::COUNT_W-1:0]     model_pages;

   bpa_pkg::rsp_type                replies_due [$];
   page_run_type                    live_runs [$];
   int                              error_count;
   int                              request_count;
   int                              reply_count;
   int                              setting_count;
   int                              status_tally [8];
   int                              cycle_count;
   int                              burst_left;

   bitmap_page_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_bitmap_page_allocator: done, errors");
         $finish;
      end
   end

   function automatic int pool_span();
      return (int'(model_pages) > bpa_pkg::POOL_PAGES) ? bpa_pkg::POOL_PAGES
                                                        : int'(model_pages);
   endfunction

   // Apply one request to the page map and return the reply it should produce.
   function automatic bpa_pkg::rsp_type update_page_map(input bpa_pkg::req_type r);
      bpa_pkg::rsp_type reply;
      int      n;
      int      cnt;
      int      i;
      int      j;
      int      k;
      int      idx;
      bit      want;
      n   = pool_span();
      cnt = int'(r.page_count);
      reply.status      = bpa_pkg::STATUS_OUT;
      reply.result_page = '0;
      if (cnt != 0 && r.operation == bpa_pkg::OP_ALLOC) begin
         reply.status = bpa_pkg::STATUS_NO_RUN;
         i = 0;
         while (i + cnt <= n) begin
            if (used_map[i]) begin
               i++;
               continue;
            end
            for (j = 1; j < cnt; j++)
               if (used_map[i + j]) break;
            if (j == cnt) begin
               for (k = 0; k < cnt; k++) used_map[i + k] = 1'b1;
               reply.status      = bpa_pkg::STATUS_OK;
               reply.result_page = model_base + bpa_pkg::PAGE_W'(i);
               break;
            end
            // skip past the used page that broke the run
            i += j + 1;
         end
      end else if (cnt != 0 && (r.operation == bpa_pkg::OP_FREE ||
                                r.operation == bpa_pkg::OP_RESERVE)) begin
         if (r.first_page >= model_base) begin
            idx = int'(r.first_page) - int'(model_base);
            if (idx <= n && cnt <= n - idx) begin
               want = (r.operation == bpa_pkg::OP_RESERVE);
               reply.status = bpa_pkg::STATUS_OK;
               for (k = 0; k < cnt; k++) begin
                  if (used_map[idx + k] == want) begin
                     reply.status = want ? bpa_pkg::STATUS_USED : bpa_pkg::STATUS_FREE;
                     break;
                  end
                  used_map[idx + k] = want;
               end
            end
         end
      end
      return reply;
   endfunction

   task automatic csr_write(input logic [bpa_pkg::CSR_AW-1:0] addr,
                            input logic [bpa_pkg::CSR_DW-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_POOL_BASE) model_base = value[bpa_pkg::PAGE_W-1:0];
      else if (addr == ADDR_POOL_PAGES) model_pages = value[bpa_pkg::COUNT_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [bpa_pkg::CSR_AW-1:0] addr,
                                 input logic [bpa_pkg::CSR_DW-1:0] want);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $error("prdata @%0h mismatch: expected %0h, got %0h", addr, want, csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Junk in the unused upper data bits must be dropped by the block.
   task automatic set_pool(input logic [bpa_pkg::PAGE_W-1:0] base,
                           input logic [bpa_pkg::COUNT_W-1:0] pages);
      csr_write(ADDR_POOL_BASE, {12'($urandom), base});
      csr_write(ADDR_POOL_PAGES, {19'($urandom), pages});
      setting_count++;
   endtask

   // Drop valid and hold until every reply has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic send_request(input bpa_pkg::req_type r);
      bpa_pkg::rsp_type reply;
      page_run_type     run;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      reply = update_page_map(r);
      replies_due.push_back(reply);
      request_count++;
      if (reply.status == bpa_pkg::STATUS_OK && r.operation == bpa_pkg::OP_ALLOC) begin
         run.first = int'(bpa_pkg::PAGE_W'(reply.result_page - model_base));
         run.count = int'(r.page_count);
         live_runs.push_back(run);
      end else if (reply.status == bpa_pkg::STATUS_OK &&
                   r.operation == bpa_pkg::OP_RESERVE) begin
         run.first = int'(r.first_page) - int'(model_base);
         run.count = int'(r.page_count);
         live_runs.push_back(run);
      end
   endtask

   task automatic request_pages(input logic [bpa_pkg::OP_W-1:0] op,
                                input logic [bpa_pkg::PAGE_W-1:0] start,
                                input logic [bpa_pkg::COUNT_W-1:0] count);
      bpa_pkg::req_type r;
      r.operation  = op;
      r.first_page = start;
      r.page_count = count;
      send_request(r);
   endtask

   task automatic hold_idle(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_paced(input bpa_pkg::req_type r, input bit steady);
      if (!steady) begin
         if (burst_left == 0) begin
            hold_idle($urandom_range(1, 8));
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      send_request(r);
   endtask

   // Mostly well-formed traffic: allocs, frees of runs known to be held,
   // reserves and frees starting inside the pool; the rest is malformed or out of range.
   function automatic bpa_pkg::req_type pick_request(input int max_cnt);
      bpa_pkg::req_type r;
      page_run_type     run;
      int               n;
      int               sel;
      int               k;
      n   = pool_span();
      sel = $urandom_range(0, 99);
      r.operation  = bpa_pkg::OP_ALLOC;
      r.first_page = bpa_pkg::PAGE_W'($urandom);
      r.page_count = bpa_pkg::COUNT_W'($urandom_range(1, max_cnt));
      if (sel < 35) begin
         if ($urandom_range(0, 9) == 0) begin
            r.page_count = bpa_pkg::COUNT_W'($urandom_range(1, (n > 0) ? n : 1));
         end
      end else if (sel < 70 && live_runs.size() > 0) begin
         k   = $urandom_range(0, live_runs.size() - 1);
         run = live_runs[k];
         live_runs.delete(k);
         r.operation  = bpa_pkg::OP_FREE;
         r.first_page = model_base + bpa_pkg::PAGE_W'(run.first);
         r.page_count = bpa_pkg::COUNT_W'(run.count);
         // overrun into whatever follows the run
         if ($urandom_range(0, 7) == 0) r.page_count = bpa_pkg::COUNT_W'(run.count + 1);
      end else if (sel < 90) begin
         r.operation  = (sel < 85) ? bpa_pkg::OP_RESERVE : bpa_pkg::OP_FREE;
         r.first_page = model_base
                      + bpa_pkg::PAGE_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               r.operation  = OP_UNUSED;
               r.page_count = bpa_pkg::COUNT_W'($urandom);
            end
            1: begin
               r.operation  = bpa_pkg::OP_W'($urandom_range(0, 2));
               r.page_count = '0;
            end
            2: begin
               r.operation  = bpa_pkg::OP_W'($urandom_range(1, 2));
               r.page_count = bpa_pkg::COUNT_W'($urandom);
            end
            default: r.page_count = bpa_pkg::COUNT_W'($urandom);
         endcase
      end
      return r;
   endfunction

   task automatic run_random_phase(input logic [bpa_pkg::PAGE_W-1:0] base, input int pages,
                                   input int items, input int max_cnt);
      page_run_type     run;
      bpa_pkg::req_type r;
      bit               steady;
      wait_drained();
      set_pool(base, bpa_pkg::COUNT_W'(pages));
      live_runs.delete();
      steady     = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      repeat (items) send_paced(pick_request(max_cnt), steady);
      // release what is still held so the next setting starts with room
      while (live_runs.size() > 0) begin
         run = live_runs.pop_front();
         r.operation  = bpa_pkg::OP_FREE;
         r.first_page = model_base + bpa_pkg::PAGE_W'(run.first);
         r.page_count = bpa_pkg::COUNT_W'(run.count);
         send_paced(r, steady);
      end
   endtask

   task automatic test_registers();
      csr_read_check(ADDR_POOL_BASE, 32'd0);
      csr_read_check(ADDR_POOL_PAGES, 32'd4096);
      set_pool(20'hFFFFF, 13'h1FFF);
      csr_read_check(ADDR_POOL_BASE, 32'h000F_FFFF);
      csr_read_check(ADDR_POOL_PAGES, 32'h0000_1FFF);
      set_pool(20'h00000, 13'h0000);
      csr_read_check(ADDR_POOL_BASE, 32'd0);
      csr_read_check(ADDR_POOL_PAGES, 32'd0);
   endtask

   task automatic test_small_pool_ops();
      set_pool(20'h00100, 13'd64);
      request_pages(bpa_pkg::OP_ALLOC,   20'h00000, 13'd1);
      request_pages(bpa_pkg::OP_ALLOC,   20'h00000, 13'd4);
      request_pages(bpa_pkg::OP_RESERVE, 20'h0010A, 13'd3);
      request_pages(bpa_pkg::OP_RESERVE, 20'h0010B, 13'd1);     // already used
      request_pages(bpa_pkg::OP_ALLOC,   20'h00000, 13'd8);     // first fit skips the short hole
      request_pages(bpa_pkg::OP_FREE,    20'h00102, 13'd2);
      request_pages(bpa_pkg::OP_FREE,    20'h00102, 13'd1);     // already free
      request_pages(bpa_pkg::OP_FREE,    20'h00100, 13'd3);     // partial clear, then stop
      request_pages(bpa_pkg::OP_ALLOC,   20'h00000, 13'd0);
      request_pages(bpa_pkg::OP_FREE,    20'h00100, 13'd0);
      request_pages(OP_UNUSED,           20'hFFFFF, 13'h1FFF);
      request_pages(bpa_pkg::OP_FREE,    20'h000FF, 13'd1);     // below the pool
      request_pages(bpa_pkg::OP_RESERVE, 20'h0013C, 13'd5);     // past the pool end
      request_pages(bpa_pkg::OP_RESERVE, 20'h0013C, 13'd4);     // ends exactly at the end
      request_pages(bpa_pkg::OP_ALLOC,   20'h00000, 13'd64);
      request_pages(bpa_pkg::OP_ALLOC,   20'h00000, 13'h1FFF);
      request_pages(bpa_pkg::OP_FREE,    20'hFFFFF, 13'd1);
      request_pages(bpa_pkg::OP_RESERVE, 20'h00100, 13'd1);
   endtask

   task automatic test_pool_limits();
      wait_drained();
      set_pool(20'h00100, 13'd0);                      // empty pool
      request_pages(bpa_pkg::OP_ALLOC,   20'h00000, 13'd1);
      request_pages(bpa_pkg::OP_RESERVE, 20'h00100, 13'd1);
      wait_drained();
      set_pool(20'hFFFFF, 13'h1FFF);                   // oversized, clamped to the map size
      request_pages(bpa_pkg::OP_ALLOC,   20'h00000, 13'd1);
      request_pages(bpa_pkg::OP_ALLOC,   20'h00000, 13'd4096);
      request_pages(bpa_pkg::OP_RESERVE, 20'h00000, 13'd1);
      wait_drained();
      set_pool(20'h00000, 13'd4096);
      request_pages(bpa_pkg::OP_RESERVE, 20'h00FFF, 13'd1);
      request_pages(bpa_pkg::OP_FREE,    20'h00FFF, 13'd2);
      request_pages(bpa_pkg::OP_FREE,    20'h00FFF, 13'd1);
   endtask

   task automatic test_random_traffic();
      run_random_phase(20'h00000, 128, 120, 8);
      run_random_phase(bpa_pkg::PAGE_W'($urandom_range(0, 20'hFF000)),
                       $urandom_range(8, 256), 120, 12);
      run_random_phase(20'hFFFFF - 20'd20, 64, 50, 6);
      run_random_phase(bpa_pkg::PAGE_W'($urandom_range(0, 20'hFE000)), 4096, 35, 16);
      run_random_phase(bpa_pkg::PAGE_W'($urandom_range(0, 20'hFE000)), 8191, 25, 16);
      run_random_phase(bpa_pkg::PAGE_W'($urandom_range(1, 20'hFFFFF)), 1, 25, 2);
      run_random_phase(bpa_pkg::PAGE_W'($urandom_range(0, 20'hFFFFF)),
                       $urandom_range(8, 64), 100, 8);
   endtask

   // receiver stall pattern: free-flowing, light, and heavy stretches
   initial begin
      int mode;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(20, 200)) begin
            @(negedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      bpa_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            $error("rsp transfer with nothing outstanding: status %0d, result_page %h",
                   rsp_data.status, rsp_data.result_page);
            error_count++;
         end else begin
            want = replies_due.pop_front();
            reply_count++;
            status_tally[want.status]++;
            if (rsp_data.status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.result_page !== want.result_page) begin
               $error("result_page mismatch: expected %h, got %h",
                      want.result_page, rsp_data.result_page);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      model_base  = '0;
      model_pages = 13'd4096;
      foreach (used_map[p]) used_map[p] = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_registers();
      test_small_pool_ops();
      test_pool_limits();
      test_random_traffic();

      wait_drained();
      repeat (64) @(posedge clock);
      $display("covered %0d requests over %0d pool settings, %0d replies checked",
               request_count, setting_count, reply_count);
      $display("  ok %0d, no run %0d, used %0d, free %0d, out of pool %0d",
               status_tally[bpa_pkg::STATUS_OK], status_tally[bpa_pkg::STATUS_NO_RUN],
               status_tally[bpa_pkg::STATUS_USED], status_tally[bpa_pkg::STATUS_FREE],
               status_tally[bpa_pkg::STATUS_OUT]);
      if (error_count == 0) begin
         $display("tb_bitmap_page_allocator: done, clean");
      end else begin
         $display("tb_bitmap_page_allocator: done, errors");
      end
      $finish;
   end

endmodule
